>>> rtl/fpa_pkg.sv
// shared constants, operation codes and pipeline stage type for the q24.8 alu
// no dependencies; every other rtl file refers to this package by scoped names
`default_nettype none

package fpa_pkg;

    localparam int FIELD_WIDTH  = 32;
    localparam int WORD_WIDTH   = 32;
    localparam int FRAC_BITS    = 8;
    localparam int ACTION_WIDTH = 4;
    localparam int DIV_WIDTH    = WORD_WIDTH + FRAC_BITS;

    typedef enum logic [ACTION_WIDTH-1:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } action_t;

    // payload carried down the pipeline alongside a separate valid bit
    typedef struct packed {
        logic                  is_div;
        logic                  div_zero;
        logic                  quo_neg;
        logic                  cmp;
        logic [WORD_WIDTH-1:0] value;
        logic [WORD_WIDTH-1:0] rem;
        logic [DIV_WIDTH-1:0]  num_quo;
        logic [WORD_WIDTH-1:0] den;
    } stage_t;

endpackage

`default_nettype wire

>>> rtl/fpa_op_if.sv
// request channel: operation code and two raw operands with valid/ready
// depends on fpa_pkg for field widths and the operation type
`default_nettype none

interface fpa_op_if;
    logic                                valid;
    logic                                ready;
    fpa_pkg::action_t                    action;
    logic signed [fpa_pkg::FIELD_WIDTH-1:0] operand_a;
    logic signed [fpa_pkg::FIELD_WIDTH-1:0] operand_b;

    modport source (output valid, action, operand_a, operand_b, input ready);
    modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

`default_nettype wire

>>> rtl/fpa_res_if.sv
// response channel: raw result and the two flags with valid/ready
// depends on fpa_pkg for field widths
`default_nettype none

interface fpa_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [fpa_pkg::FIELD_WIDTH-1:0] result_value;
    logic                                compare_true;
    logic                                divide_by_zero;

    modport source (output valid, result_value, compare_true, divide_by_zero, input ready);
    modport sink   (input valid, result_value, compare_true, divide_by_zero, output ready);
endinterface

`default_nettype wire

>>> rtl/fpa_prep.sv
// first pipeline stage: multiplier, adders, compares and divider operand set-up
// depends on fpa_pkg
`default_nettype none

module fpa_prep (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              enable,
    input  wire logic                              valid,
    input  wire fpa_pkg::action_t                  action,
    input  wire logic [fpa_pkg::FIELD_WIDTH-1:0]   operand_a,
    input  wire logic [fpa_pkg::FIELD_WIDTH-1:0]   operand_b,
    output logic                                   valid_reg,
    output fpa_pkg::stage_t                        stage_reg
);

    logic signed [fpa_pkg::WORD_WIDTH-1:0]   a_s;
    logic signed [fpa_pkg::WORD_WIDTH-1:0]   b_s;
    logic signed [2*fpa_pkg::WORD_WIDTH-1:0] prod;
    logic [fpa_pkg::WORD_WIDTH-1:0]          a_mag;
    logic [fpa_pkg::WORD_WIDTH-1:0]          b_mag;
    logic                                    lt;
    logic                                    eq;
    fpa_pkg::stage_t                         stage_next;

    assign a_s  = $signed(operand_a[fpa_pkg::WORD_WIDTH-1:0]);
    assign b_s  = $signed(operand_b[fpa_pkg::WORD_WIDTH-1:0]);
    assign prod = a_s * b_s;
    assign lt   = a_s < b_s;
    assign eq   = a_s == b_s;

    // magnitudes for the unsigned divider, the most negative word fits unsigned
    assign a_mag = a_s[fpa_pkg::WORD_WIDTH-1] ? fpa_pkg::WORD_WIDTH'(-a_s)
                                              : fpa_pkg::WORD_WIDTH'(a_s);
    assign b_mag = b_s[fpa_pkg::WORD_WIDTH-1] ? fpa_pkg::WORD_WIDTH'(-b_s)
                                              : fpa_pkg::WORD_WIDTH'(b_s);

    always_comb
    begin
        stage_next          = '0;
        stage_next.num_quo  = fpa_pkg::DIV_WIDTH'(a_mag) << fpa_pkg::FRAC_BITS;
        stage_next.den      = b_mag;
        stage_next.quo_neg  = a_s[fpa_pkg::WORD_WIDTH-1] ^ b_s[fpa_pkg::WORD_WIDTH-1];
        unique case (action)
            fpa_pkg::OP_ADD:      stage_next.value = a_s + b_s;
            fpa_pkg::OP_SUB:      stage_next.value = a_s - b_s;
            fpa_pkg::OP_MUL:
                stage_next.value = prod[fpa_pkg::FRAC_BITS +: fpa_pkg::WORD_WIDTH];
            fpa_pkg::OP_DIV:
            begin
                stage_next.is_div   = 1'b1;
                stage_next.div_zero = (b_s == '0);
            end
            fpa_pkg::OP_GT:       stage_next.cmp = !lt && !eq;
            fpa_pkg::OP_LT:       stage_next.cmp = lt;
            fpa_pkg::OP_GE:       stage_next.cmp = !lt;
            fpa_pkg::OP_LE:       stage_next.cmp = lt || eq;
            fpa_pkg::OP_EQ:       stage_next.cmp = eq;
            fpa_pkg::OP_NE:       stage_next.cmp = !eq;
            fpa_pkg::OP_MIN:      stage_next.value = lt ? a_s : b_s;
            fpa_pkg::OP_MAX:      stage_next.value = lt ? b_s : a_s;
            fpa_pkg::OP_INC:      stage_next.value = a_s + 1'b1;
            fpa_pkg::OP_DEC:      stage_next.value = a_s - 1'b1;
            fpa_pkg::OP_FROM_INT: stage_next.value = a_s << fpa_pkg::FRAC_BITS;
            fpa_pkg::OP_TO_INT:   stage_next.value = a_s >>> fpa_pkg::FRAC_BITS;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fpa_div_stage.sv
// one restoring division step: one quotient bit per stage, payload rides along
// depends on fpa_pkg
`default_nettype none

module fpa_div_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            enable,
    input  wire logic            valid_in,
    input  wire fpa_pkg::stage_t stage_in,
    output logic                 valid_reg,
    output fpa_pkg::stage_t      stage_reg
);

    logic [fpa_pkg::WORD_WIDTH:0] shifted;
    logic [fpa_pkg::WORD_WIDTH:0] diff;
    logic                         fits;
    fpa_pkg::stage_t              stage_next;

    assign shifted = {stage_in.rem, stage_in.num_quo[fpa_pkg::DIV_WIDTH-1]};
    assign diff    = shifted - {1'b0, stage_in.den};
    assign fits    = !diff[fpa_pkg::WORD_WIDTH];

    always_comb
    begin
        stage_next         = stage_in;
        stage_next.rem     = fits ? diff[fpa_pkg::WORD_WIDTH-1:0]
                                  : shifted[fpa_pkg::WORD_WIDTH-1:0];
        // dividend bits leave at the top, quotient bits enter at the bottom
        stage_next.num_quo = {stage_in.num_quo[fpa_pkg::DIV_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fpa_finish.sv
// last stage: quotient sign fix, result select and the output register
// depends on fpa_pkg
`default_nettype none

module fpa_finish (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            enable,
    input  wire logic                            valid_in,
    input  wire fpa_pkg::stage_t                 stage_in,
    output logic                                 valid_reg,
    output logic [fpa_pkg::FIELD_WIDTH-1:0]      result_value_reg,
    output logic                                 compare_true_reg,
    output logic                                 divide_by_zero_reg
);

    logic [fpa_pkg::WORD_WIDTH-1:0]  quo;
    logic [fpa_pkg::WORD_WIDTH-1:0]  word_next;
    logic [fpa_pkg::FIELD_WIDTH-1:0] result_value_next;

    // only the low word of the quotient survives the wrap
    assign quo = stage_in.num_quo[fpa_pkg::WORD_WIDTH-1:0];

    always_comb
    begin
        priority if (stage_in.is_div && stage_in.div_zero)
            word_next = '0;
        else if (stage_in.is_div)
            word_next = stage_in.quo_neg ? -quo : quo;
        else
            word_next = stage_in.value;
    end

    assign result_value_next = fpa_pkg::FIELD_WIDTH'($signed(word_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            result_value_reg   <= result_value_next;
            compare_true_reg   <= stage_in.cmp;
            divide_by_zero_reg <= stage_in.is_div && stage_in.div_zero;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fixed_point_q24_8_alu.sv
// signed q24.8 alu, one result per operation, fully pipelined
// the pipe runs through the prep stage, 40 divider bit stages and the
//   output stage; the divider step chain sets the depth
// throughput: one operation per cycle while the response side keeps taking
// reset: rst_n is asynchronous active low and clears every stage valid bit
// depends on fpa_pkg, fpa_op_if, fpa_res_if, fpa_prep, fpa_div_stage, fpa_finish
`default_nettype none

module fixed_point_q24_8_alu (
    input  wire logic clk,
    input  wire logic rst_n,
    fpa_op_if.sink    request,
    fpa_res_if.source response
);

    // the whole pipe moves as one; it holds only when a finished result waits
    logic advance;

    // stage chain: index 0 is the prep output, index DIV_WIDTH the last divider step
    logic            chain_valid [0:fpa_pkg::DIV_WIDTH];
    fpa_pkg::stage_t chain_stage [0:fpa_pkg::DIV_WIDTH];

    logic                            out_valid;
    logic [fpa_pkg::FIELD_WIDTH-1:0] out_value;
    logic                            out_cmp;
    logic                            out_dz;

    assign advance       = !out_valid || response.ready;
    assign request.ready = advance;

    // decode, add/sub/compare, 32x32 multiply and divider operand set-up
    fpa_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (advance),
        .valid     (request.valid),
        .action    (request.action),
        .operand_a (request.operand_a),
        .operand_b (request.operand_b),
        .valid_reg (chain_valid[0]),
        .stage_reg (chain_stage[0])
    );

    // restoring divider, one quotient bit per stage over the shifted dividend;
    // non-divide results simply ride through to keep the order
    for (genvar i = 0; i < fpa_pkg::DIV_WIDTH; i++)
    begin : g_div
        fpa_div_stage u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .enable    (advance),
            .valid_in  (chain_valid[i]),
            .stage_in  (chain_stage[i]),
            .valid_reg (chain_valid[i+1]),
            .stage_reg (chain_stage[i+1])
        );
    end

    // sign correction of the quotient, final select and output register
    fpa_finish u_finish (
        .clk                (clk),
        .rst_n              (rst_n),
        .enable             (advance),
        .valid_in           (chain_valid[fpa_pkg::DIV_WIDTH]),
        .stage_in           (chain_stage[fpa_pkg::DIV_WIDTH]),
        .valid_reg          (out_valid),
        .result_value_reg   (out_value),
        .compare_true_reg   (out_cmp),
        .divide_by_zero_reg (out_dz)
    );

    assign response.valid          = out_valid;
    assign response.result_value   = out_value;
    assign response.compare_true   = out_cmp;
    assign response.divide_by_zero = out_dz;

endmodule

`default_nettype wire

>>> verif/fixed_point_q24_8_alu_test.sv
// self-checking testbench for the q24.8 fixed-point alu: directed table, then random operations
// depends on fpa_pkg, fpa_op_if, fpa_res_if and the fixed_point_q24_8_alu rtl
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_test;

    import fpa_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_OPS    = 800;
    // pipeline is 42 deep, so this comfortably covers the drain after the last transfer
    localparam int DRAIN_CYCLES  = 100;
    // slowest legal run is a long gap, then a long stall, for every operation,
    // and this limit sits close to ten times above it
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_OFF_LEN  = 200;
    localparam int HOLD_OFF_AT   = 250;

    typedef logic signed [FIELD_WIDTH-1:0] word_t;

    localparam word_t WORD_MIN = 32'sh8000_0000;
    localparam word_t WORD_MAX = 32'sh7fff_ffff;

    // one response as the alu should present it
    typedef struct packed {
        word_t value;
        logic  cmp;
        logic  dz;
    } alu_result_t;

    // one row of the directed table; known marks rows whose answer is typed in
    typedef struct packed {
        action_t action;
        word_t   a;
        word_t   b;
        logic    known;
        word_t   value;
        logic    cmp;
        logic    dz;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 24;

    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // 1.0 + 2.0
        '{OP_ADD,      32'sh0000_0100, 32'sh0000_0200, 1'b1, 32'sh0000_0300, 1'b0, 1'b0},
        // add wraps past the top of the range
        '{OP_ADD,      WORD_MAX,       32'sh0000_0001, 1'b1, WORD_MIN,       1'b0, 1'b0},
        // sub wraps past the bottom
        '{OP_SUB,      WORD_MIN,       32'sh0000_0001, 1'b1, WORD_MAX,       1'b0, 1'b0},
        // 1.5 * 2.0
        '{OP_MUL,      32'sh0000_0180, 32'sh0000_0200, 1'b1, 32'sh0000_0300, 1'b0, 1'b0},
        // most negative squared, product overflows the word
        '{OP_MUL,      WORD_MIN,       WORD_MIN,       1'b0, 32'sh0,         1'b0, 1'b0},
        // tiny negative product shifts toward minus infinity
        '{OP_MUL,      32'shffff_ffff, 32'sh0000_0001, 1'b1, 32'shffff_ffff, 1'b0, 1'b0},
        '{OP_MUL,      WORD_MAX,       WORD_MAX,       1'b0, 32'sh0,         1'b0, 1'b0},
        // 3.0 / 2.0
        '{OP_DIV,      32'sh0000_0300, 32'sh0000_0200, 1'b1, 32'sh0000_0180, 1'b0, 1'b0},
        // zero divisor: value cleared and flag raised
        '{OP_DIV,      32'sh1234_5678, 32'sh0,         1'b1, 32'sh0,         1'b0, 1'b1},
        '{OP_DIV,      WORD_MIN,       32'sh0,         1'b1, 32'sh0,         1'b0, 1'b1},
        // most negative over minus one raw
        '{OP_DIV,      WORD_MIN,       32'shffff_ffff, 1'b0, 32'sh0,         1'b0, 1'b0},
        // quotient truncates toward zero, not down
        '{OP_DIV,      32'shffff_ffff, 32'sh0000_0200, 1'b1, 32'sh0,         1'b0, 1'b0},
        // compares leave the value at zero
        '{OP_GT,       WORD_MAX,       WORD_MIN,       1'b1, 32'sh0,         1'b1, 1'b0},
        '{OP_LT,       WORD_MIN,       WORD_MAX,       1'b1, 32'sh0,         1'b1, 1'b0},
        '{OP_GE,       32'sh0000_0500, 32'sh0000_0500, 1'b1, 32'sh0,         1'b1, 1'b0},
        '{OP_LE,       32'sh0000_0001, 32'sh0000_0000, 1'b1, 32'sh0,         1'b0, 1'b0},
        '{OP_EQ,       WORD_MIN,       WORD_MIN,       1'b1, 32'sh0,         1'b1, 1'b0},
        '{OP_NE,       WORD_MAX,       WORD_MAX,       1'b1, 32'sh0,         1'b0, 1'b0},
        '{OP_MIN,      WORD_MIN,       WORD_MAX,       1'b1, WORD_MIN,       1'b0, 1'b0},
        '{OP_MAX,      WORD_MIN,       WORD_MAX,       1'b1, WORD_MAX,       1'b0, 1'b0},
        // unary ops ignore operand b, so give it a loud value
        '{OP_INC,      WORD_MAX,       WORD_MIN,       1'b1, WORD_MIN,       1'b0, 1'b0},
        '{OP_DEC,      WORD_MIN,       WORD_MAX,       1'b1, WORD_MAX,       1'b0, 1'b0},
        // integer conversion out of range wraps
        '{OP_FROM_INT, 32'sh0080_0000, 32'shffff_ffff, 1'b1, WORD_MIN,       1'b0, 1'b0},
        // to_int floors, so a tiny negative becomes minus one
        '{OP_TO_INT,   32'shffff_ffff, 32'sh0,         1'b1, 32'shffff_ffff, 1'b0, 1'b0}
    };

    logic clk;
    logic rst_n;

    fpa_op_if  request_ch ();
    fpa_res_if response_ch ();

    fixed_point_q24_8_alu u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch.sink),
        .response (response_ch.source)
    );

    alu_result_t expected_results [$];
    int unsigned mismatch_count;
    int unsigned results_seen;
    int unsigned cycle_count;
    bit          burst_mode;

    // clock
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // bit-exact behaviour of one operation; products and quotients are worked out at 64 bits, then wrapped
    function automatic alu_result_t predict_alu(input action_t op, input word_t a, input word_t b);
        alu_result_t      r;
        logic signed [63:0] a_wide;
        logic signed [63:0] b_wide;
        logic signed [63:0] wide;
        a_wide  = a;
        b_wide  = b;
        wide    = '0;
        r.value = '0;
        r.cmp   = 1'b0;
        r.dz    = 1'b0;
        case (op)
            OP_ADD:      r.value = a + b;
            OP_SUB:      r.value = a - b;
            OP_MUL:
            begin
                wide    = (a_wide * b_wide) >>> FRAC_BITS;
                r.value = wide[FIELD_WIDTH-1:0];
            end
            OP_DIV:
            begin
                if (b == 0)
                begin
                    r.dz = 1'b1;
                end
                else
                begin
                    // signed division in sv truncates toward zero
                    wide    = (a_wide <<< FRAC_BITS) / b_wide;
                    r.value = wide[FIELD_WIDTH-1:0];
                end
            end
            OP_GT:       r.cmp = (a > b);
            OP_LT:       r.cmp = (a < b);
            OP_GE:       r.cmp = (a >= b);
            OP_LE:       r.cmp = (a <= b);
            OP_EQ:       r.cmp = (a == b);
            OP_NE:       r.cmp = (a != b);
            OP_MIN:      r.value = (a < b) ? a : b;
            OP_MAX:      r.value = (a < b) ? b : a;
            OP_INC:      r.value = a + 32'sd1;
            OP_DEC:      r.value = a - 32'sd1;
            OP_FROM_INT: r.value = a <<< FRAC_BITS;
            default:     r.value = a >>> FRAC_BITS;
        endcase
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap(input bit no_gaps);
        int unsigned roll;
        if (no_gaps)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // operand mix: raw random words, small fixed-point values, whole numbers and the corners
    function automatic word_t pick_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            4, 5, 6:    return int'($urandom_range(0, 8191)) - 4096;
            7:
            begin
                case ($urandom_range(0, 5))
                    0:       return WORD_MIN;
                    1:       return WORD_MAX;
                    2:       return 32'sh0;
                    3:       return 32'shffff_ffff;
                    4:       return 32'sh1;
                    default: return 32'sh100;
                endcase
            end
            default:    return (int'($urandom_range(0, 200)) - 100) <<< FRAC_BITS;
        endcase
    endfunction

    // offer one operation and hold it until the alu takes it; entered and left on a falling edge
    task automatic send_operation(input action_t op, input word_t a, input word_t b,
                                  input alu_result_t want);
        int unsigned gap;
        gap = pick_gap(burst_mode);
        if (gap != 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        request_ch.valid     <= 1'b1;
        request_ch.action    <= op;
        request_ch.operand_a <= a;
        request_ch.operand_b <= b;
        do
            @(posedge clk);
        while (!request_ch.ready);
        // transfer happened at this edge
        expected_results.push_back(want);
        @(negedge clk);
    endtask

    // main sequence: reset, directed table, random operations, drain, verdict
    initial
    begin
        action_t     op;
        word_t       a;
        word_t       b;
        alu_result_t want;

        request_ch.valid     = 1'b0;
        request_ch.action    = OP_ADD;
        request_ch.operand_a = '0;
        request_ch.operand_b = '0;
        burst_mode           = 1'b0;
        mismatch_count       = 0;
        rst_n                = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part: typed-in answers where obvious, predictor elsewhere
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            if (DIRECTED_ROWS[i].known)
            begin
                want.value = DIRECTED_ROWS[i].value;
                want.cmp   = DIRECTED_ROWS[i].cmp;
                want.dz    = DIRECTED_ROWS[i].dz;
            end
            else
            begin
                want = predict_alu(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].a,
                                   DIRECTED_ROWS[i].b);
            end
            send_operation(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].a,
                           DIRECTED_ROWS[i].b, want);
        end

        // random part, with stretches of back-to-back transfers
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 64 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            op = action_t'($urandom_range(0, 15));
            a  = pick_operand();
            b  = pick_operand();
            // equal operands for the compares, zero divisors for div
            if ($urandom_range(0, 9) == 0)
                b = a;
            else if (op == OP_DIV && $urandom_range(0, 11) == 0)
                b = '0;
            send_operation(op, a, b, predict_alu(op, a, b));
        end
        request_ch.valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        // let anything stray fall out of the pipeline
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // response side: random stalls, long clear runs, and one long hold-off to back the pipe up
    initial
    begin
        int unsigned busy_len;
        int unsigned run_len;
        bit          hold_off_done;

        response_ch.ready = 1'b0;
        hold_off_done     = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            busy_len = pick_gap(1'b0);
            if (!hold_off_done && results_seen >= HOLD_OFF_AT)
            begin
                busy_len      = HOLD_OFF_LEN;
                hold_off_done = 1'b1;
            end
            if (busy_len != 0)
            begin
                response_ch.ready <= 1'b0;
                repeat (busy_len) @(negedge clk);
            end
            response_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                run_len = $urandom_range(100, 300);
            else
                run_len = $urandom_range(1, 20);
            repeat (run_len) @(negedge clk);
        end
    end

    // check every response transfer against the oldest outstanding prediction
    always @(posedge clk)
    begin
        alu_result_t want;
        if (rst_n && response_ch.valid && response_ch.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected response transfer, actual value %h cmp %b dz %b",
                         $time, response_ch.result_value, response_ch.compare_true,
                         response_ch.divide_by_zero);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (response_ch.result_value !== want.value)
                begin
                    $display("%0t: result_value expected %h, actual %h",
                             $time, want.value, response_ch.result_value);
                    mismatch_count++;
                end
                if (response_ch.compare_true !== want.cmp)
                begin
                    $display("%0t: compare_true expected %b, actual %b",
                             $time, want.cmp, response_ch.compare_true);
                    mismatch_count++;
                end
                if (response_ch.divide_by_zero !== want.dz)
                begin
                    $display("%0t: divide_by_zero expected %b, actual %b",
                             $time, want.dz, response_ch.divide_by_zero);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    initial cycle_count = 0;
    initial results_seen = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

>>> filelist.f
rtl/fpa_pkg.sv
rtl/fpa_op_if.sv
rtl/fpa_res_if.sv
rtl/fpa_prep.sv
rtl/fpa_div_stage.sv
rtl/fpa_finish.sv
rtl/fixed_point_q24_8_alu.sv
verif/fixed_point_q24_8_alu_test.sv
